// ===== design/periodic_task_timer_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Periodic task timer table: assertion macros
// Shared concurrent assertion forms, clocked on clock, idle in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define PTT_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task timer table: package
// Field widths, operation and result codes, slot entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

   localparam int FUNC_W      = 2;
   localparam int TICKS_W     = 16;
   localparam int SLOT_W      = 4;
   localparam int KIND_W      = 3;
   localparam int PEND_W      = 8;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_DELETE   = 2'd1,
      FUNC_TICK     = 2'd2,
      FUNC_DISPATCH = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED   = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_DELETED = 3'd2,
      KIND_BAD     = 3'd3,
      KIND_TICK    = 3'd4,
      KIND_RUN     = 3'd5,
      KIND_NONE    = 3'd6
   } kind_type;

   typedef struct packed {
      logic                valid;
      logic [TICKS_W-1:0]  delay_left;
      logic [TICKS_W-1:0]  reload_period;
      logic [PEND_W-1:0]   pending_runs;
   } slot_entry_type;

endpackage

`default_nettype wire

// ===== design/ptt_channels.sv =====
// ----------------------------------------------------------------------------
// Periodic task timer table: channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptt_req_if
   import ptt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [TICKS_W-1:0]  first_delay;
   logic [TICKS_W-1:0]  repeat_period;
   logic [SLOT_W-1:0]   target_slot;

   modport source (output valid, func, first_delay, repeat_period, target_slot,
                   input ready);
   modport sink   (input valid, func, first_delay, repeat_period, target_slot,
                   output ready);
endinterface

interface ptt_rsp_if
   import ptt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SLOT_W-1:0]   task_slot;
   logic                last;

   modport source (output valid, kind, task_slot, last, input ready);
   modport sink   (input valid, kind, task_slot, last, output ready);
endinterface

`default_nettype wire

// ===== design/periodic_task_timer_table_core.sv =====
// Flow: a request is taken only while idle; the ring then scans every slot, and
//   results found in the scan wait in a hold register before the output register.
// Throughput: one slot passes the ring head per cycle, and the ring holds while
//   the response register is occupied and its response is not taken.
// Reset: synchronous; every slot is freed and the sequencer returns to idle.
// ----------------------------------------------------------------------------
// Periodic task timer table: top level
// Add, delete, tick and dispatch over a ring of task slot cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_timer_table_core
   import ptt_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ptt_req_if.sink   req_chan,
   ptt_rsp_if.source rsp_chan
);

   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = (SW > SLOT_W) ? SW : SLOT_W;
   localparam logic [SW-1:0] LAST_CNT = SW'(TASK_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type           state_ff,        state_in;
   logic [SW-1:0]       cnt_ff,          cnt_in;
   logic [RES_CNT_W-1:0] n_ff,           n_in;
   func_type            func_ff,         func_in;
   logic [TICKS_W-1:0]  delay_ff,        delay_in;
   logic [TICKS_W-1:0]  period_ff,       period_in;
   logic [SLOT_W-1:0]   target_ff,       target_in;
   logic                hold_valid_ff,   hold_valid_in;
   kind_type            hold_kind_ff,    hold_kind_in;
   logic [SLOT_W-1:0]   hold_slot_ff,    hold_slot_in;
   logic                rsp_valid_ff,    rsp_valid_in;
   kind_type            rsp_kind_ff,     rsp_kind_in;
   logic [SLOT_W-1:0]   rsp_slot_ff,     rsp_slot_in;
   logic                rsp_last_ff,     rsp_last_in;

   slot_entry_type head;
   slot_entry_type tail;
   logic           shift_en;
   logic           out_free;
   logic [SLOT_W-1:0] cur_slot;

   ptt_ring #(
      .SLOTS (TASK_SLOTS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (shift_en),
      .tail_entry (tail),
      .head_entry (head)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cur_slot = SLOT_W'(cnt_ff);

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.task_slot = rsp_slot_ff;
   assign rsp_chan.last      = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      func_in       = func_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      target_in     = target_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_slot_in  = hold_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      tail          = head;
      shift_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in       = func_type'(req_chan.func);
               delay_in      = req_chan.first_delay;
               period_in     = req_chan.repeat_period;
               target_in     = req_chan.target_slot;
               cnt_in        = '0;
               n_in          = '0;
               hold_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               shift_en = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == LAST_CNT) begin
                  state_in = ST_FINISH;
               end
               case (func_ff)
                  FUNC_ADD: begin
                     if (!head.valid && !hold_valid_ff) begin
                        tail.valid         = 1'b1;
                        tail.delay_left    = delay_ff;
                        tail.reload_period = period_ff;
                        tail.pending_runs  = '0;
                        hold_valid_in      = 1'b1;
                        hold_kind_in       = KIND_ADDED;
                        hold_slot_in       = cur_slot;
                     end
                  end
                  FUNC_DELETE: begin
                     if (head.valid && (CW'(cnt_ff) == CW'(target_ff))) begin
                        tail          = '0;
                        hold_valid_in = 1'b1;
                        hold_kind_in  = KIND_DELETED;
                        hold_slot_in  = target_ff;
                     end
                  end
                  FUNC_TICK: begin
                     if (head.valid) begin
                        if (head.delay_left == '0) begin
                           if (head.pending_runs != PEND_MAX) begin
                              tail.pending_runs = head.pending_runs + 1'b1;
                           end
                           if (head.reload_period != '0) begin
                              tail.delay_left = head.reload_period;
                           end
                        end else begin
                           tail.delay_left = head.delay_left - 1'b1;
                        end
                     end
                  end
                  FUNC_DISPATCH: begin
                     if (head.valid && (head.pending_runs != '0) &&
                         (n_ff < RES_CNT_W'(MAX_RESULTS))) begin
                        if (head.reload_period == '0) begin
                           tail = '0;
                        end else begin
                           tail.pending_runs = head.pending_runs - 1'b1;
                        end
                        if (hold_valid_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = hold_kind_ff;
                           rsp_slot_in  = hold_slot_ff;
                           rsp_last_in  = 1'b0;
                        end
                        hold_valid_in = 1'b1;
                        hold_kind_in  = KIND_RUN;
                        hold_slot_in  = cur_slot;
                        n_in          = n_ff + 1'b1;
                     end
                  end
                  default: begin
                     tail = head;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_slot_in  = '0;
               if (hold_valid_ff) begin
                  rsp_kind_in = hold_kind_ff;
                  rsp_slot_in = hold_slot_ff;
               end else begin
                  case (func_ff)
                     FUNC_ADD:      rsp_kind_in = KIND_FULL;
                     FUNC_DELETE: begin
                        rsp_kind_in = KIND_BAD;
                        rsp_slot_in = target_ff;
                     end
                     FUNC_TICK:     rsp_kind_in = KIND_TICK;
                     FUNC_DISPATCH: rsp_kind_in = KIND_NONE;
                     default:       rsp_kind_in = KIND_NONE;
                  endcase
               end
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         n_ff          <= n_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff      <= func_in;
      delay_ff     <= delay_in;
      period_ff    <= period_in;
      target_ff    <= target_in;
      hold_kind_ff <= hold_kind_in;
      hold_slot_ff <= hold_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== design/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// Periodic task timer table: slot cell
// Holds one slot entry; loads its neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_cell
   import ptt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           shift_en,
   input  wire slot_entry_type next_entry,
   output slot_entry_type      entry
);

   slot_entry_type entry_ff;
   slot_entry_type entry_in;

   assign entry_in = shift_en ? next_entry : entry_ff;
   assign entry    = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ptt_ring.sv =====
// ----------------------------------------------------------------------------
// Periodic task timer table: slot ring
// Chain of slot cells; each shift moves every entry one cell toward the head
// and loads the updated head entry into the tail cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_ring
   import ptt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           shift_en,
   input  wire slot_entry_type tail_entry,
   output slot_entry_type      head_entry
);

   slot_entry_type cell_out [SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      slot_entry_type feed;
      if (i == SLOTS - 1) begin : g_tail
         assign feed = tail_entry;
      end else begin : g_mid
         assign feed = cell_out[i+1];
      end
      ptt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .next_entry (feed),
         .entry      (cell_out[i])
      );
   end

   assign head_entry = cell_out[0];

endmodule

`default_nettype wire

// ===== design/ptt_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic task timer table: port checker
// Watches the channel ports for response ordering and request blocking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_timer_table_core_defines.svh"

module ptt_checker
   import ptt_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [SLOT_W-1:0] rsp_slot,
   input wire logic              rsp_last
);

   `PTT_ASSERT_NEXT(a_rsp_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_slot) && $stable(rsp_last), "response changed while stalled")
   `PTT_ASSERT(a_single_is_last, rsp_valid && (rsp_kind != KIND_RUN), rsp_last, "non-run result without last")
   `PTT_ASSERT(a_more_only_run, rsp_valid && !rsp_last, rsp_kind == KIND_RUN, "non-final result is not a run")
   `PTT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_slot  (rsp_chan.task_slot),
   .rsp_last  (rsp_chan.last)
);

`default_nettype wire

// ===== bench/ptt_schedule_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task timer table: schedule monitor
// Watches both channels, keeps its own copy of the slot table, works out the
// results of every request transfer and checks each response transfer
// against the oldest result still owed.
// ----------------------------------------------------------------------------

module ptt_schedule_monitor
   import ptt_pkg::*;
#(
   parameter int TASK_SLOTS = 16
) (
   input  logic clock,
   input  logic reset,
   ptt_req_if   req_chan,
   ptt_rsp_if   rsp_chan,
   output int   mismatches,
   output int   awaited
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] task_slot;
      logic              last;
   } sched_result_type;

   logic               slot_busy [TASK_SLOTS];
   logic [TICKS_W-1:0] countdown [TASK_SLOTS];
   logic [TICKS_W-1:0] period_of [TASK_SLOTS];
   logic [PEND_W-1:0]  runs_owed [TASK_SLOTS];
   sched_result_type   due_q [$];

   function automatic void release_slot(int s);
      slot_busy[s] = 1'b0;
      countdown[s] = '0;
      period_of[s] = '0;
      runs_owed[s] = '0;
   endfunction

   function automatic void owe(kind_type k, int s, logic l);
      sched_result_type r;
      r.kind      = k;
      r.task_slot = SLOT_W'(s);
      r.last      = l;
      due_q.push_back(r);
   endfunction

   function automatic void schedule_step(func_type op, logic [TICKS_W-1:0] delay,
                                         logic [TICKS_W-1:0] period,
                                         logic [SLOT_W-1:0] target);
      int               n;
      bit               placed;
      sched_result_type tail;
      n      = 0;
      placed = 0;
      case (op)
         FUNC_ADD: begin
            for (int s = 0; s < TASK_SLOTS && !placed; s++) begin
               if (!slot_busy[s]) begin
                  slot_busy[s] = 1'b1;
                  countdown[s] = delay;
                  period_of[s] = period;
                  runs_owed[s] = '0;
                  owe(KIND_ADDED, s, 1'b1);
                  placed = 1;
               end
            end
            if (!placed)
               owe(KIND_FULL, 0, 1'b1);
         end
         FUNC_DELETE: begin
            if (int'(target) < TASK_SLOTS && slot_busy[target]) begin
               release_slot(int'(target));
               owe(KIND_DELETED, int'(target), 1'b1);
            end else begin
               owe(KIND_BAD, int'(target), 1'b1);
            end
         end
         FUNC_TICK: begin
            for (int s = 0; s < TASK_SLOTS; s++) begin
               if (slot_busy[s]) begin
                  if (countdown[s] == '0) begin
                     if (runs_owed[s] != PEND_MAX)
                        runs_owed[s] = runs_owed[s] + 1'b1;
                     if (period_of[s] != '0)
                        countdown[s] = period_of[s];
                  end else begin
                     countdown[s] = countdown[s] - 1'b1;
                  end
               end
            end
            owe(KIND_TICK, 0, 1'b1);
         end
         FUNC_DISPATCH: begin
            for (int s = 0; s < TASK_SLOTS && n < MAX_RESULTS; s++) begin
               if (slot_busy[s] && runs_owed[s] != '0) begin
                  owe(KIND_RUN, s, 1'b0);
                  n++;
                  runs_owed[s] = runs_owed[s] - 1'b1;
                  if (period_of[s] == '0)
                     release_slot(s);
               end
            end
            if (n == 0) begin
               owe(KIND_NONE, 0, 1'b1);
            end else begin
               tail      = due_q.pop_back();
               tail.last = 1'b1;
               due_q.push_back(tail);
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         for (int s = 0; s < TASK_SLOTS; s++)
            release_slot(s);
         due_q.delete();
         mismatches = 0;
      end else begin
         // response first: it can never belong to a request taken this edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual kind %0d slot %0d last %0b",
                        $time, rsp_chan.kind, rsp_chan.task_slot, rsp_chan.last);
               mismatches = mismatches + 1;
            end else begin
               want = due_q.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                           rsp_chan.kind);
                  mismatches = mismatches + 1;
               end
               if (rsp_chan.task_slot !== want.task_slot) begin
                  $display("%0t: task_slot expected %0d actual %0d (kind %0d)", $time,
                           want.task_slot, rsp_chan.task_slot, want.kind);
                  mismatches = mismatches + 1;
               end
               if (rsp_chan.last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b (kind %0d)", $time,
                           want.last, rsp_chan.last, want.kind);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            schedule_step(func_type'(req_chan.func), req_chan.first_delay,
                          req_chan.repeat_period, req_chan.target_slot);
      end
      awaited <= due_q.size();
   end

endmodule

// ===== bench/periodic_task_timer_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task timer table: testbench top
// Drives add, delete, tick and dispatch requests with random gaps while the
// response side stalls at random; a schedule monitor beside the block checks
// every response. Covers empty and full tables, one-shot and periodic tasks,
// run-count saturation and a full sixteen-run dispatch.
// ----------------------------------------------------------------------------

module periodic_task_timer_table_core_tb;
   import ptt_pkg::*;

   localparam int TASK_SLOTS  = 16;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock;
   logic reset;
   logic quiet;
   int   mismatches;
   int   awaited;
   int   hold_left;
   int   cycle_count = 0;

   ptt_req_if req_chan ();
   ptt_rsp_if rsp_chan ();

   periodic_task_timer_table_core #(
      .TASK_SLOTS(TASK_SLOTS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   ptt_schedule_monitor #(
      .TASK_SLOTS(TASK_SLOTS)
   ) sched_check (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mismatches(mismatches),
      .awaited   (awaited)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_task_timer_table_core_tb: errors");
         $finish;
      end
   end

   // response-side stalls
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
         hold_left      <= 0;
      end else if (hold_left == 0) begin
         if (rsp_chan.ready && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= $urandom_range(0, 12);
         end else begin
            rsp_chan.ready <= 1'b1;
            hold_left      <= $urandom_range(1, 20);
         end
      end else begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic send_op(input func_type op, input logic [TICKS_W-1:0] delay,
                          input logic [TICKS_W-1:0] period,
                          input logic [SLOT_W-1:0] target);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.func          <= op;
      req_chan.first_delay   <= delay;
      req_chan.repeat_period <= period;
      req_chan.target_slot   <= target;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random_op(input int add_pct);
      int                 pick;
      func_type           op;
      logic [TICKS_W-1:0] delay;
      logic [TICKS_W-1:0] period;
      pick = $urandom_range(0, 99);
      if (pick < add_pct)
         op = FUNC_ADD;
      else if (pick < add_pct + 15)
         op = FUNC_DELETE;
      else if (pick < add_pct + 35)
         op = FUNC_DISPATCH;
      else
         op = FUNC_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         delay = TICKS_W'($urandom_range(0, 3));
      else if (pick == 7)
         delay = '1;
      else
         delay = TICKS_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4)
         period = '0;
      else if (pick < 8)
         period = TICKS_W'($urandom_range(1, 4));
      else if (pick == 8)
         period = '1;
      else
         period = TICKS_W'($urandom);
      send_op(op, delay, period, SLOT_W'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (awaited != 0);
   endtask

   initial begin
      int add_pct;
      reset                  = 1'b1;
      quiet                  = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_ADD;
      req_chan.first_delay   = '0;
      req_chan.repeat_period = '0;
      req_chan.target_slot   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table, then fill it with the field extremes
      send_op(FUNC_DISPATCH, '0, '0, '0);
      send_op(FUNC_TICK, '1, '1, '1);
      send_op(FUNC_DELETE, '0, '0, 4'd0);
      send_op(FUNC_DELETE, '1, '1, 4'd15);
      for (int k = 0; k < 16; k++)
         send_op(FUNC_ADD, (k < 14) ? 16'h0000 : 16'hFFFF,
                 (k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'h0001 : 16'hFFFF,
                 SLOT_W'(15 - k));
      send_op(FUNC_ADD, 16'h0005, 16'h0005, '0);
      send_op(FUNC_TICK, '0, '0, '0);
      send_op(FUNC_DISPATCH, '0, '0, '0);
      send_op(FUNC_DELETE, '0, '0, 4'd15);
      send_op(FUNC_DELETE, '0, '0, 4'd3);

      add_pct = 30;
      for (int k = 0; k < 160; k++) begin
         if (k % 40 == 0)
            add_pct = $urandom_range(10, 45);
         send_random_op(add_pct);
      end

      req_chan.valid <= 1'b0;
      wait_drained();

      // clear and refill, then tick long enough to saturate one-shot run counts
      for (int k = 0; k < 16; k++)
         send_op(FUNC_DELETE, TICKS_W'($urandom), TICKS_W'($urandom), SLOT_W'(k));
      for (int k = 0; k < 16; k++)
         send_op(FUNC_ADD, '0,
                 (k % 4 == 0) ? 16'h0000 : (k % 4 == 1) ? 16'h0001 :
                 TICKS_W'($urandom_range(2, 300)), SLOT_W'($urandom));
      repeat (260)
         send_op(FUNC_TICK, TICKS_W'($urandom), TICKS_W'($urandom), SLOT_W'($urandom));
      repeat (3)
         send_op(FUNC_DISPATCH, TICKS_W'($urandom), TICKS_W'($urandom), SLOT_W'($urandom));

      quiet = 1'b1;
      for (int k = 0; k < 50; k++)
         send_random_op(30);

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("periodic_task_timer_table_core_tb: clean");
      else
         $display("periodic_task_timer_table_core_tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/ptt_pkg.sv
design/ptt_channels.sv
design/ptt_cell.sv
design/ptt_ring.sv
design/periodic_task_timer_table_core.sv
design/ptt_checker.sv
bench/ptt_schedule_monitor.sv
bench/periodic_task_timer_table_core_tb.sv
